// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the point rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is high.
`define GRP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define GRP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/grp_pkg.sv =====
// ----------------------------------------------------------------------------
// grp_pkg
// Shared types, constants and helpers for the grain region point rotation.
// ----------------------------------------------------------------------------
`default_nettype none

package grp_pkg;

   // Default widths of the datapath
   localparam int COORD_WIDTH_DEF = 28;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int ID_WIDTH_DEF    = 20;

   // Fixed field widths
   localparam int TYPE_WIDTH = 4;
   localparam int LEN_WIDTH  = 27;
   localparam int RSQ_WIDTH  = 56;
   localparam int TRIG_WIDTH = 18;

   // X, y or sphere-mode z offsets of magnitude 2^LIM_BITS+ are outside the grain
   localparam int LIM_BITS = 28;

   // Register port
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_INDEX_LSB  = 3;

   localparam logic signed [TRIG_WIDTH-1:0] COS_RESET = 18'sh10000;
   localparam logic signed [TRIG_WIDTH-1:0] SIN_RESET = 18'sh00000;

   typedef enum logic [2:0] {
      REG_BOX_LEN_X       = 3'd0,
      REG_BOX_LEN_Y       = 3'd1,
      REG_BOX_LEN_Z       = 3'd2,
      REG_GRAIN_RADIUS_SQ = 3'd3,
      REG_COS_ANGLE       = 3'd4,
      REG_SIN_ANGLE       = 3'd5,
      REG_SPHERE_MODE     = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [LEN_WIDTH-1:0]         box_len_x;
      logic [LEN_WIDTH-1:0]         box_len_y;
      logic [LEN_WIDTH-1:0]         box_len_z;
      logic [RSQ_WIDTH-1:0]         grain_radius_sq;
      logic signed [TRIG_WIDTH-1:0] cos_angle;
      logic signed [TRIG_WIDTH-1:0] sin_angle;
      logic                         sphere_mode;
   } cfg_type;

   // Width of a centred offset: position minus half box length, exactly
   function automatic int offset_width(input int cw);
      return ((cw > LEN_WIDTH) ? cw : LEN_WIDTH) + 1;
   endfunction

   // Half box length, dropping the low bit
   function automatic logic [LEN_WIDTH-2:0] half_len(input logic [LEN_WIDTH-1:0] len);
      return len[LEN_WIDTH-1:1];
   endfunction

endpackage

`default_nettype wire

// ===== sv/grp_csr.sv =====
// ----------------------------------------------------------------------------
// grp_csr
// Configuration registers behind a simple APB-style write/read port.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grp_csr
   import grp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      psel,
   input  wire logic                      penable,
   input  wire logic                      pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] prdata,
   output logic                           pready,
   output cfg_type                        cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[CSR_ADDR_WIDTH-1:CSR_INDEX_LSB]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Decode the write into the next register image; unknown slots are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_BOX_LEN_X:       cfg_in.box_len_x       = pwdata[LEN_WIDTH-1:0];
            REG_BOX_LEN_Y:       cfg_in.box_len_y       = pwdata[LEN_WIDTH-1:0];
            REG_BOX_LEN_Z:       cfg_in.box_len_z       = pwdata[LEN_WIDTH-1:0];
            REG_GRAIN_RADIUS_SQ: cfg_in.grain_radius_sq = pwdata[RSQ_WIDTH-1:0];
            REG_COS_ANGLE:       cfg_in.cos_angle       = $signed(pwdata[TRIG_WIDTH-1:0]);
            REG_SIN_ANGLE:       cfg_in.sin_angle       = $signed(pwdata[TRIG_WIDTH-1:0]);
            REG_SPHERE_MODE:     cfg_in.sphere_mode     = pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_len_x       <= '0;
         cfg_ff.box_len_y       <= '0;
         cfg_ff.box_len_z       <= '0;
         cfg_ff.grain_radius_sq <= '0;
         cfg_ff.cos_angle       <= COS_RESET;
         cfg_ff.sin_angle       <= SIN_RESET;
         cfg_ff.sphere_mode     <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (idx)
         REG_BOX_LEN_X:       prdata = CSR_DATA_WIDTH'(cfg_ff.box_len_x);
         REG_BOX_LEN_Y:       prdata = CSR_DATA_WIDTH'(cfg_ff.box_len_y);
         REG_BOX_LEN_Z:       prdata = CSR_DATA_WIDTH'(cfg_ff.box_len_z);
         REG_GRAIN_RADIUS_SQ: prdata = CSR_DATA_WIDTH'(cfg_ff.grain_radius_sq);
         REG_COS_ANGLE:
            prdata = {{(CSR_DATA_WIDTH-TRIG_WIDTH){1'b0}}, cfg_ff.cos_angle};
         REG_SIN_ANGLE:
            prdata = {{(CSR_DATA_WIDTH-TRIG_WIDTH){1'b0}}, cfg_ff.sin_angle};
         REG_SPHERE_MODE:     prdata = CSR_DATA_WIDTH'(cfg_ff.sphere_mode);
         default:             prdata = '0;
      endcase
   end

   `GRP_ASSERT(a_cos_write, clock, reset, (wr_en && idx == REG_COS_ANGLE) |=> (cfg_ff.cos_angle == $past(pwdata[TRIG_WIDTH-1:0])), "cosine write lost")

endmodule

`default_nettype wire

// ===== sv/grp_offset.sv =====
// ----------------------------------------------------------------------------
// grp_offset
// First stage: move each position to box-centred offsets.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_offset
   import grp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cfg_type                            cfg,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic        [ID_WIDTH-1:0]    in_id,
   input  wire logic        [TYPE_WIDTH-1:0]  in_type,
   input  wire logic signed [COORD_WIDTH-1:0] in_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_z,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic        [ID_WIDTH-1:0]         out_id,
   output logic        [TYPE_WIDTH-1:0]       out_type,
   output logic signed [COORD_WIDTH-1:0]      out_x,
   output logic signed [COORD_WIDTH-1:0]      out_y,
   output logic signed [COORD_WIDTH-1:0]      out_z,
   output logic signed [offset_width(COORD_WIDTH)-1:0] out_dx,
   output logic signed [offset_width(COORD_WIDTH)-1:0] out_dy,
   output logic signed [offset_width(COORD_WIDTH)-1:0] out_dz
);

   localparam int DW = offset_width(COORD_WIDTH);

   logic                          valid_ff;
   logic        [ID_WIDTH-1:0]    id_ff;
   logic        [TYPE_WIDTH-1:0]  type_ff;
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff, z_ff;
   logic signed [DW-1:0]          dx_ff, dy_ff, dz_ff;
   logic signed [DW-1:0]          dx_in, dy_in, dz_in;

   // Subtract half the box length on each axis
   assign dx_in = DW'(in_x) - $signed(DW'(half_len(cfg.box_len_x)));
   assign dy_in = DW'(in_y) - $signed(DW'(half_len(cfg.box_len_y)));
   assign dz_in = DW'(in_z) - $signed(DW'(half_len(cfg.box_len_z)));

   assign in_ready = !valid_ff || out_ready;

   // Advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the request payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         id_ff   <= in_id;
         type_ff <= in_type;
         x_ff    <= in_x;
         y_ff    <= in_y;
         z_ff    <= in_z;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_id    = id_ff;
   assign out_type  = type_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_dx    = dx_ff;
   assign out_dy    = dy_ff;
   assign out_dz    = dz_ff;

endmodule

`default_nettype wire

// ===== sv/grp_product.sv =====
// ----------------------------------------------------------------------------
// grp_product
// Second stage: squares of the offsets, rotation products and range flags.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_product
   import grp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cfg_type                            cfg,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic        [ID_WIDTH-1:0]    in_id,
   input  wire logic        [TYPE_WIDTH-1:0]  in_type,
   input  wire logic signed [COORD_WIDTH-1:0] in_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_z,
   input  wire logic signed [offset_width(COORD_WIDTH)-1:0] in_dx,
   input  wire logic signed [offset_width(COORD_WIDTH)-1:0] in_dy,
   input  wire logic signed [offset_width(COORD_WIDTH)-1:0] in_dz,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic        [ID_WIDTH-1:0]         out_id,
   output logic        [TYPE_WIDTH-1:0]       out_type,
   output logic signed [COORD_WIDTH-1:0]      out_x,
   output logic signed [COORD_WIDTH-1:0]      out_y,
   output logic signed [COORD_WIDTH-1:0]      out_z,
   output logic        [2*offset_width(COORD_WIDTH)-2:0] out_sq_x,
   output logic        [2*offset_width(COORD_WIDTH)-2:0] out_sq_y,
   output logic        [2*offset_width(COORD_WIDTH)-2:0] out_sq_z,
   output logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] out_xc,
   output logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] out_ys,
   output logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] out_xs,
   output logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] out_yc,
   output logic                               out_near_xy,
   output logic                               out_near_z
);

   localparam int DW  = offset_width(COORD_WIDTH);
   localparam int PW  = DW + TRIG_WIDTH;
   localparam int SQW = 2 * DW - 1;
   localparam int EW  = ((DW > LIM_BITS + 1) ? DW : LIM_BITS + 1) + 1;
   localparam logic signed [EW-1:0] LIM_POS = EW'(64'd1 << LIM_BITS);
   localparam logic signed [EW-1:0] LIM_NEG = -LIM_POS;

   logic                          valid_ff;
   logic        [ID_WIDTH-1:0]    id_ff;
   logic        [TYPE_WIDTH-1:0]  type_ff;
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff, z_ff;
   logic signed [2*DW-1:0]        sq_x_in, sq_y_in, sq_z_in;
   logic        [SQW-1:0]         sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [PW-1:0]          xc_in, ys_in, xs_in, yc_in;
   logic signed [PW-1:0]          xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [EW-1:0]          ex, ey, ez;
   logic                          near_xy_in, near_z_in;
   logic                          near_xy_ff, near_z_ff;

   // Square each offset; the square of a signed value is never negative
   assign sq_x_in = in_dx * in_dx;
   assign sq_y_in = in_dy * in_dy;
   assign sq_z_in = in_dz * in_dz;

   // Form the four rotation products
   assign xc_in = in_dx * cfg.cos_angle;
   assign ys_in = in_dy * cfg.sin_angle;
   assign xs_in = in_dx * cfg.sin_angle;
   assign yc_in = in_dy * cfg.cos_angle;

   // Flag offsets small enough to take part in the radius test
   assign ex         = EW'(in_dx);
   assign ey         = EW'(in_dy);
   assign ez         = EW'(in_dz);
   assign near_xy_in = (ex < LIM_POS) && (ex > LIM_NEG) && (ey < LIM_POS) && (ey > LIM_NEG);
   assign near_z_in  = (ez < LIM_POS) && (ez > LIM_NEG);

   assign in_ready = !valid_ff || out_ready;

   // Advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the stage payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         id_ff      <= in_id;
         type_ff    <= in_type;
         x_ff       <= in_x;
         y_ff       <= in_y;
         z_ff       <= in_z;
         sq_x_ff    <= sq_x_in[SQW-1:0];
         sq_y_ff    <= sq_y_in[SQW-1:0];
         sq_z_ff    <= sq_z_in[SQW-1:0];
         xc_ff      <= xc_in;
         ys_ff      <= ys_in;
         xs_ff      <= xs_in;
         yc_ff      <= yc_in;
         near_xy_ff <= near_xy_in;
         near_z_ff  <= near_z_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_id      = id_ff;
   assign out_type    = type_ff;
   assign out_x       = x_ff;
   assign out_y       = y_ff;
   assign out_z       = z_ff;
   assign out_sq_x    = sq_x_ff;
   assign out_sq_y    = sq_y_ff;
   assign out_sq_z    = sq_z_ff;
   assign out_xc      = xc_ff;
   assign out_ys      = ys_ff;
   assign out_xs      = xs_ff;
   assign out_yc      = yc_ff;
   assign out_near_xy = near_xy_ff;
   assign out_near_z  = near_z_ff;

endmodule

`default_nettype wire

// ===== sv/grp_resolve.sv =====
// ----------------------------------------------------------------------------
// grp_resolve
// Third stage: radius test against the grain and rotation sums.
// ----------------------------------------------------------------------------
`default_nettype none

module grp_resolve
   import grp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  cfg_type                            cfg,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire logic        [ID_WIDTH-1:0]    in_id,
   input  wire logic        [TYPE_WIDTH-1:0]  in_type,
   input  wire logic signed [COORD_WIDTH-1:0] in_x,
   input  wire logic signed [COORD_WIDTH-1:0] in_y,
   input  wire logic signed [COORD_WIDTH-1:0] in_z,
   input  wire logic        [2*offset_width(COORD_WIDTH)-2:0] in_sq_x,
   input  wire logic        [2*offset_width(COORD_WIDTH)-2:0] in_sq_y,
   input  wire logic        [2*offset_width(COORD_WIDTH)-2:0] in_sq_z,
   input  wire logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] in_xc,
   input  wire logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] in_ys,
   input  wire logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] in_xs,
   input  wire logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH-1:0] in_yc,
   input  wire logic                          in_near_xy,
   input  wire logic                          in_near_z,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic        [ID_WIDTH-1:0]         out_id,
   output logic        [TYPE_WIDTH-1:0]       out_type,
   output logic signed [COORD_WIDTH-1:0]      out_x,
   output logic signed [COORD_WIDTH-1:0]      out_y,
   output logic signed [COORD_WIDTH-1:0]      out_z,
   output logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH:0] out_rot_x,
   output logic signed [offset_width(COORD_WIDTH)+TRIG_WIDTH:0] out_rot_y,
   output logic                               out_inside
);

   localparam int DW  = offset_width(COORD_WIDTH);
   localparam int PW  = DW + TRIG_WIDTH;
   localparam int SQW = 2 * DW - 1;
   localparam int SW  = SQW + 2;

   logic                          valid_ff;
   logic        [ID_WIDTH-1:0]    id_ff;
   logic        [TYPE_WIDTH-1:0]  type_ff;
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff, z_ff;
   logic        [SW-1:0]          dist_sq;
   logic signed [PW:0]            rot_x_in, rot_y_in;
   logic signed [PW:0]            rot_x_ff, rot_y_ff;
   logic                          inside_in, inside_ff;

   // Sum the squares, with z only for a spherical grain, and test the radius
   assign dist_sq   = SW'(in_sq_x) + SW'(in_sq_y) + (cfg.sphere_mode ? SW'(in_sq_z) : SW'(0));
   assign inside_in = in_near_xy && (!cfg.sphere_mode || in_near_z) &&
                      (dist_sq <= SW'(cfg.grain_radius_sq));

   // Combine the products into the rotated offsets
   assign rot_x_in = in_xc - in_ys;
   assign rot_y_in = in_xs + in_yc;

   assign in_ready = !valid_ff || out_ready;

   // Advance the valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   // Load the stage payload
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         id_ff     <= in_id;
         type_ff   <= in_type;
         x_ff      <= in_x;
         y_ff      <= in_y;
         z_ff      <= in_z;
         rot_x_ff  <= rot_x_in;
         rot_y_ff  <= rot_y_in;
         inside_ff <= inside_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_id     = id_ff;
   assign out_type   = type_ff;
   assign out_x      = x_ff;
   assign out_y      = y_ff;
   assign out_z      = z_ff;
   assign out_rot_x  = rot_x_ff;
   assign out_rot_y  = rot_y_ff;
   assign out_inside = inside_ff;

endmodule

`default_nettype wire

// ===== sv/grain_region_point_rotation.sv =====
// Throughput: one request per cycle while the result channel is not stalled;
// four register stages (offset, multiply, radius test and sums, shift-back
// and saturate) each hold one request. A stall holds the last stage and the
// full stages just behind it; empty stages keep filling.
// Reset (synchronous, active high) empties the pipeline and restores the
// registers to their defaults; no memory needs clearing.
// ----------------------------------------------------------------------------
// grain_region_point_rotation
// Rotates atom positions about the box centre when they lie inside the grain.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module grain_region_point_rotation
   import grp_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF,
   parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic        [ID_WIDTH-1:0]    req_atom_id,
   input  wire logic        [TYPE_WIDTH-1:0]  req_atom_type,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  wire logic signed [COORD_WIDTH-1:0] req_pos_z,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic        [ID_WIDTH-1:0]         rsp_out_id,
   output logic        [TYPE_WIDTH-1:0]       rsp_out_type,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_x,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_y,
   output logic signed [COORD_WIDTH-1:0]      rsp_new_z,
   output logic                               rsp_inside_grain,
   // register port
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int DW  = offset_width(COORD_WIDTH);
   localparam int PW  = DW + TRIG_WIDTH;
   localparam int SQW = 2 * DW - 1;
   localparam int RW  = PW + 2;

   cfg_type cfg;

   // Stage one to two
   logic                          s1_valid, s1_ready;
   logic        [ID_WIDTH-1:0]    s1_id;
   logic        [TYPE_WIDTH-1:0]  s1_type;
   logic signed [COORD_WIDTH-1:0] s1_x, s1_y, s1_z;
   logic signed [DW-1:0]          s1_dx, s1_dy, s1_dz;

   // Stage two to three
   logic                          s2_valid, s2_ready;
   logic        [ID_WIDTH-1:0]    s2_id;
   logic        [TYPE_WIDTH-1:0]  s2_type;
   logic signed [COORD_WIDTH-1:0] s2_x, s2_y, s2_z;
   logic        [SQW-1:0]         s2_sq_x, s2_sq_y, s2_sq_z;
   logic signed [PW-1:0]          s2_xc, s2_ys, s2_xs, s2_yc;
   logic                          s2_near_xy, s2_near_z;

   // Stage three to output
   logic                          s3_valid, s3_ready;
   logic        [ID_WIDTH-1:0]    s3_id;
   logic        [TYPE_WIDTH-1:0]  s3_type;
   logic signed [COORD_WIDTH-1:0] s3_x, s3_y, s3_z;
   logic signed [PW:0]            s3_rot_x, s3_rot_y;
   logic                          s3_inside;

   // Output stage
   logic                          valid_ff;
   logic        [ID_WIDTH-1:0]    id_ff;
   logic        [TYPE_WIDTH-1:0]  type_ff;
   logic signed [COORD_WIDTH-1:0] new_x_ff, new_y_ff, new_z_ff;
   logic signed [COORD_WIDTH-1:0] new_x_in, new_y_in;
   logic                          inside_ff;
   logic signed [PW:0]            shift_x, shift_y;
   logic signed [RW-1:0]          back_x, back_y;

   grp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   grp_offset #(
      .COORD_WIDTH (COORD_WIDTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_offset (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_id     (req_atom_id),
      .in_type   (req_atom_type),
      .in_x      (req_pos_x),
      .in_y      (req_pos_y),
      .in_z      (req_pos_z),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_id    (s1_id),
      .out_type  (s1_type),
      .out_x     (s1_x),
      .out_y     (s1_y),
      .out_z     (s1_z),
      .out_dx    (s1_dx),
      .out_dy    (s1_dy),
      .out_dz    (s1_dz)
   );

   grp_product #(
      .COORD_WIDTH (COORD_WIDTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_product (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .in_valid    (s1_valid),
      .in_ready    (s1_ready),
      .in_id       (s1_id),
      .in_type     (s1_type),
      .in_x        (s1_x),
      .in_y        (s1_y),
      .in_z        (s1_z),
      .in_dx       (s1_dx),
      .in_dy       (s1_dy),
      .in_dz       (s1_dz),
      .out_valid   (s2_valid),
      .out_ready   (s2_ready),
      .out_id      (s2_id),
      .out_type    (s2_type),
      .out_x       (s2_x),
      .out_y       (s2_y),
      .out_z       (s2_z),
      .out_sq_x    (s2_sq_x),
      .out_sq_y    (s2_sq_y),
      .out_sq_z    (s2_sq_z),
      .out_xc      (s2_xc),
      .out_ys      (s2_ys),
      .out_xs      (s2_xs),
      .out_yc      (s2_yc),
      .out_near_xy (s2_near_xy),
      .out_near_z  (s2_near_z)
   );

   grp_resolve #(
      .COORD_WIDTH (COORD_WIDTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_resolve (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (s2_valid),
      .in_ready   (s2_ready),
      .in_id      (s2_id),
      .in_type    (s2_type),
      .in_x       (s2_x),
      .in_y       (s2_y),
      .in_z       (s2_z),
      .in_sq_x    (s2_sq_x),
      .in_sq_y    (s2_sq_y),
      .in_sq_z    (s2_sq_z),
      .in_xc      (s2_xc),
      .in_ys      (s2_ys),
      .in_xs      (s2_xs),
      .in_yc      (s2_yc),
      .in_near_xy (s2_near_xy),
      .in_near_z  (s2_near_z),
      .out_valid  (s3_valid),
      .out_ready  (s3_ready),
      .out_id     (s3_id),
      .out_type   (s3_type),
      .out_x      (s3_x),
      .out_y      (s3_y),
      .out_z      (s3_z),
      .out_rot_x  (s3_rot_x),
      .out_rot_y  (s3_rot_y),
      .out_inside (s3_inside)
   );

   // Clamp a wide signed value to the coordinate range
   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [RW-1:0] v
   );
      logic [RW-COORD_WIDTH:0] upper;
      upper = v[RW-1:COORD_WIDTH-1];
      if ((&upper) || !(|upper)) begin
         return v[COORD_WIDTH-1:0];
      end else if (v[RW-1]) begin
         return {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         return {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
   endfunction

   // For inside points drop the fraction bits, shift back to box origin and clamp
   assign shift_x  = s3_rot_x >>> FRAC_BITS;
   assign shift_y  = s3_rot_y >>> FRAC_BITS;
   assign back_x   = RW'(shift_x) + $signed(RW'(half_len(cfg.box_len_x)));
   assign back_y   = RW'(shift_y) + $signed(RW'(half_len(cfg.box_len_y)));
   assign new_x_in = s3_inside ? sat_coord(back_x) : s3_x;
   assign new_y_in = s3_inside ? sat_coord(back_y) : s3_y;

   assign s3_ready = !valid_ff || rsp_ready;

   // Advance the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (s3_ready) begin
         valid_ff <= s3_valid;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (s3_valid && s3_ready) begin
         id_ff     <= s3_id;
         type_ff   <= s3_type;
         new_x_ff  <= new_x_in;
         new_y_ff  <= new_y_in;
         new_z_ff  <= s3_z;
         inside_ff <= s3_inside;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_id       = id_ff;
   assign rsp_out_type     = type_ff;
   assign rsp_new_x        = new_x_ff;
   assign rsp_new_y        = new_y_ff;
   assign rsp_new_z        = new_z_ff;
   assign rsp_inside_grain = inside_ff;

   `GRP_ASSERT(a_full_stall, clock, reset, !req_ready |-> rsp_valid, "request stalled with result slot empty")
   `GRP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

`default_nettype wire
